@@ src/ttr_pkg.sv @@
`timescale 1ns / 1ps

package ttr_pkg;

    // Field widths
    localparam int IDX_W      = 32;
    localparam int VAL_W      = 64;
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = SIZE_W - 1;
    localparam int NUM_DIMS   = 4;
    localparam int DIM_W      = 2;
    localparam int CNT_W      = 3;
    localparam int DIMN_W     = 4;

    // Highest dimension count honoured, 1 to 4
    localparam int MAX_DIMS        = 4;
    localparam int VALUE_WIDTH_DEF = 64;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEP = 8;

    // Partial sums of the index rebuild
    localparam int T2_W = 16;
    localparam int T1_W = 24;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(256);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIM_COUNT,
        REG_SIZE_DIM0,
        REG_SIZE_DIM1,
        REG_SIZE_DIM2,
        REG_SIZE_DIM3,
        REG_SWAP_FIRST,
        REG_SWAP_SECOND
    } cfg_reg_e;

    typedef struct packed {
        logic [IDX_W-1:0] src_index;
        logic [VAL_W-1:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic [VAL_W-1:0] out_value;
        logic             range_error;
    } out_item_t;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [NUM_DIMS-1:0][SIZE_W-1:0] size;
        logic [DIM_W-1:0]                swap_a;
        logic [DIM_W-1:0]                swap_b;
        logic                            swap_err;
    } cfg_eff_t;

    // Dimension count clamped to 1..MAX_DIMS
    function automatic logic [DIMN_W-1:0] eff_dim_count(input logic [CNT_W-1:0] raw);
        logic [DIMN_W-1:0] n;
        n = DIMN_W'(raw);
        if (n == '0)
            n = DIMN_W'(1);
        else if (n > DIMN_W'(MAX_DIMS))
            n = DIMN_W'(MAX_DIMS);
        return n;
    endfunction

    // Size of dimension d: 1 when unused or zero, capped at 256
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                   input int unsigned       d,
                                                   input logic [DIMN_W-1:0] n);
        logic [SIZE_W-1:0] s;
        if (DIMN_W'(d) >= n || raw == '0)
            s = SIZE_W'(1);
        else if (raw > SIZE_CAP)
            s = SIZE_CAP;
        else
            s = raw;
        return s;
    endfunction

    // Source dimension that lands in place d after the exchange
    function automatic logic [DIM_W-1:0] perm_dim(input logic [DIM_W-1:0] d,
                                                  input logic [DIM_W-1:0] a,
                                                  input logic [DIM_W-1:0] b);
        logic [DIM_W-1:0] p;
        if (d == a)
            p = b;
        else if (d == b)
            p = a;
        else
            p = d;
        return p;
    endfunction

endpackage

@@ src/ttr_cfg.sv @@
`timescale 1ns / 1ps

module ttr_cfg
    import ttr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_eff_t              eff
);

    logic [CNT_W-1:0]                dim_count_reg, dim_count_next;
    logic [NUM_DIMS-1:0][SIZE_W-1:0] size_reg, size_next;
    logic [DIM_W-1:0]                swap_first_reg, swap_first_next;
    logic [DIM_W-1:0]                swap_second_reg, swap_second_next;
    logic [DIMN_W-1:0]               n_eff;

    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        dim_count_next   = dim_count_reg;
        size_next        = size_reg;
        swap_first_next  = swap_first_reg;
        swap_second_next = swap_second_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_DIM_COUNT:   dim_count_next   = cfg_data[CNT_W-1:0];
                REG_SIZE_DIM0:   size_next[0]     = cfg_data[SIZE_W-1:0];
                REG_SIZE_DIM1:   size_next[1]     = cfg_data[SIZE_W-1:0];
                REG_SIZE_DIM2:   size_next[2]     = cfg_data[SIZE_W-1:0];
                REG_SIZE_DIM3:   size_next[3]     = cfg_data[SIZE_W-1:0];
                REG_SWAP_FIRST:  swap_first_next  = cfg_data[DIM_W-1:0];
                REG_SWAP_SECOND: swap_second_next = cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg   <= CNT_W'(1);
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                size_reg[d] <= SIZE_W'(1);
            end
            swap_first_reg  <= '0;
            swap_second_reg <= '0;
        end
        else
        begin
            dim_count_reg   <= dim_count_next;
            size_reg        <= size_next;
            swap_first_reg  <= swap_first_next;
            swap_second_reg <= swap_second_next;
        end
    end

    // Effective sizes and swap range check
    assign n_eff = eff_dim_count(dim_count_reg);

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            eff.size[d] = eff_size(size_reg[d], d, n_eff);
        end
        eff.swap_a   = swap_first_reg;
        eff.swap_b   = swap_second_reg;
        eff.swap_err = (DIMN_W'(swap_first_reg) >= n_eff) ||
                       (DIMN_W'(swap_second_reg) >= n_eff);
    end

endmodule

@@ src/ttr_div.sv @@
`timescale 1ns / 1ps

module ttr_div
    import ttr_pkg::*;
#(
    parameter int SIDE_W = VALUE_WIDTH_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IDX_W-1:0]   dividend,
    input  logic [SIZE_W-1:0]  divisor,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   quotient,
    output logic [COORD_W-1:0] remainder,
    output logic [SIDE_W-1:0]  side_out
);

    localparam int STAGES = IDX_W / DIV_STEP;

    logic [STAGES-1:0]  valid_reg;
    logic [IDX_W-1:0]   word_reg  [STAGES];
    logic [COORD_W-1:0] rem_reg   [STAGES];
    logic [SIDE_W-1:0]  side_reg  [STAGES];
    logic [IDX_W-1:0]   word_next [STAGES];
    logic [COORD_W-1:0] rem_next  [STAGES];

    logic [STAGES-1:0]  stage_valid;
    logic [IDX_W-1:0]   word_feed [STAGES];
    logic [COORD_W-1:0] rem_feed  [STAGES];
    logic [SIDE_W-1:0]  side_feed [STAGES];
    logic [STAGES:0]    stage_ready;

    assign stage_ready[STAGES] = out_ready;
    assign in_ready            = stage_ready[0];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            // Stage input: ports for the first, previous register otherwise
            if (s == 0)
            begin : g_first
                assign stage_valid[s] = in_valid;
                assign word_feed[s]   = dividend;
                assign rem_feed[s]    = '0;
                assign side_feed[s]   = side_in;
            end
            else
            begin : g_rest
                assign stage_valid[s] = valid_reg[s-1];
                assign word_feed[s]   = word_reg[s-1];
                assign rem_feed[s]    = rem_reg[s-1];
                assign side_feed[s]   = side_reg[s-1];
            end

            assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

            // Restoring division, DIV_STEP quotient bits shifted in
            always_comb
            begin : div_step
                logic [COORD_W-1:0] r;
                logic [IDX_W-1:0]   w;
                logic [SIZE_W-1:0]  trial;
                logic               ge;
                r = rem_feed[s];
                w = word_feed[s];
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    trial = {r, w[IDX_W-1]};
                    ge    = (trial >= divisor);
                    w     = {w[IDX_W-2:0], ge};
                    if (ge)
                        trial = trial - divisor;
                    r = trial[COORD_W-1:0];
                end
                word_next[s] = w;
                rem_next[s]  = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (stage_ready[s])
                    valid_reg[s] <= stage_valid[s];
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[s] && stage_valid[s])
                begin
                    word_reg[s] <= word_next[s];
                    rem_reg[s]  <= rem_next[s];
                    side_reg[s] <= side_feed[s];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = word_reg[STAGES-1];
    assign remainder = rem_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

@@ src/ttr_rebuild.sv @@
`timescale 1ns / 1ps

module ttr_rebuild
    import ttr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfg_eff_t                          cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [IDX_W-1:0]                  top_quot,
    input  logic [NUM_DIMS-2:0][COORD_W-1:0]  coord_in,
    input  logic [VALUE_WIDTH-1:0]            value_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output out_item_t                         out_data
);

    logic [NUM_DIMS-1:0][COORD_W-1:0] coord;
    logic [DIM_W-1:0]                 p0, p1, p2, p3;
    logic                             ready1, ready2, ready3;

    logic                      s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [T2_W-1:0]           t2_reg, t2_next;
    logic [COORD_W-1:0]        c0a_reg, c1a_reg, c0b_reg;
    logic                      err1_reg, err1_next, err2_reg;
    logic [VALUE_WIDTH-1:0]    val1_reg, val2_reg;
    logic [T1_W-1:0]           t1_reg, t1_next;
    out_item_t                 out_data_reg, out_data_next;

    logic [SIZE_W+COORD_W-1:0] t2_full;
    logic [SIZE_W+T2_W-1:0]    t1_full;
    logic [SIZE_W+T1_W-1:0]    t0_full;

    // Ready chain: a stage moves when empty or when its successor moves
    assign ready3   = !out_valid_reg || out_ready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_ready = ready1;

    // Last coordinate is the remaining quotient when the index is in range
    assign coord = {top_quot[COORD_W-1:0], coord_in};

    assign p0 = perm_dim(DIM_W'(0), cfg.swap_a, cfg.swap_b);
    assign p1 = perm_dim(DIM_W'(1), cfg.swap_a, cfg.swap_b);
    assign p2 = perm_dim(DIM_W'(2), cfg.swap_a, cfg.swap_b);
    assign p3 = perm_dim(DIM_W'(3), cfg.swap_a, cfg.swap_b);

    // Stage 1: range check and innermost multiply-add
    always_comb
    begin
        err1_next = (top_quot >= IDX_W'(cfg.size[NUM_DIMS-1]));
        t2_full   = cfg.size[p2] * coord[p3] + coord[p2];
        t2_next   = t2_full[T2_W-1:0];
    end

    // Stage 2
    always_comb
    begin
        t1_full = cfg.size[p1] * t2_reg + c1a_reg;
        t1_next = t1_full[T1_W-1:0];
    end

    // Stage 3: final multiply-add, error forces destination to zero
    always_comb
    begin
        t0_full                   = cfg.size[p0] * t1_reg + c0b_reg;
        out_data_next.range_error = err2_reg || cfg.swap_err;
        out_data_next.dest_index  = out_data_next.range_error ? '0 : t0_full[IDX_W-1:0];
        out_data_next.out_value   = VAL_W'(val2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= in_valid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            t2_reg   <= t2_next;
            c0a_reg  <= coord[p0];
            c1a_reg  <= coord[p1];
            err1_reg <= err1_next;
            val1_reg <= value_in;
        end
        if (ready2 && s1_valid_reg)
        begin
            t1_reg   <= t1_next;
            c0b_reg  <= c0a_reg;
            err2_reg <= err1_reg;
            val2_reg <= val1_reg;
        end
        if (ready3 && s2_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/tensor_transpose_remap.sv @@
`timescale 1ns / 1ps

// Transposition index remapper.
// in channel (in_valid/in_ready/in_data): one element per transaction, its
// linear source index and raw value. out channel (out_valid/out_ready/
// out_data): the destination index in the transposed layout, the value
// masked to VALUE_WIDTH bits, and range_error (destination forced to 0).
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; a
// write takes effect at the next cycle; the user must make writes only
// while no element is in flight, which the block itself does not enforce.
// The path from input to output transaction has twelve divider
// stages (three divisions by the sizes of dimensions 0 to 2, eight
// quotient bits per stage) and three multiply-add stages that rebuild the
// index. Throughput is one transaction per cycle while out_ready is high.
// Every stage holds its own valid bit; a stalled receiver holds the output
// register and back-pressure reaches in_ready only once all stages ahead
// are full, so bubbles are squeezed out and nothing is lost or repeated.
// Reset empties the pipeline and restores the registers to one dimension
// of size 1 with both swap dimensions 0.

module tensor_transpose_remap
    import ttr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIDE0_W = VALUE_WIDTH;
    localparam int SIDE1_W = VALUE_WIDTH + COORD_W;
    localparam int SIDE2_W = VALUE_WIDTH + 2 * COORD_W;

    cfg_eff_t eff;

    logic               v0, r0, v1, r1, v2, r2;
    logic [IDX_W-1:0]   q0, q1, q2;
    logic [COORD_W-1:0] c0, c1, c2;
    logic [SIDE0_W-1:0] side0;
    logic [SIDE1_W-1:0] side1;
    logic [SIDE2_W-1:0] side2;

    logic [NUM_DIMS-2:0][COORD_W-1:0] coord_low;

    // Configuration registers
    ttr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    // Coordinate of dimension 0
    ttr_div #(.SIDE_W(SIDE0_W)) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dividend  (in_data.src_index),
        .divisor   (eff.size[0]),
        .side_in   (in_data.elem_value[VALUE_WIDTH-1:0]),
        .out_valid (v0),
        .out_ready (r0),
        .quotient  (q0),
        .remainder (c0),
        .side_out  (side0)
    );

    // Coordinate of dimension 1
    ttr_div #(.SIDE_W(SIDE1_W)) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0),
        .in_ready  (r0),
        .dividend  (q0),
        .divisor   (eff.size[1]),
        .side_in   ({side0, c0}),
        .out_valid (v1),
        .out_ready (r1),
        .quotient  (q1),
        .remainder (c1),
        .side_out  (side1)
    );

    // Coordinate of dimension 2
    ttr_div #(.SIDE_W(SIDE2_W)) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .dividend  (q1),
        .divisor   (eff.size[2]),
        .side_in   ({side1, c1}),
        .out_valid (v2),
        .out_ready (r2),
        .quotient  (q2),
        .remainder (c2),
        .side_out  (side2)
    );

    // side2 holds {value, c0, c1}; coordinates packed as {c2, c1, c0}
    assign coord_low = {c2, side2[COORD_W-1:0], side2[2*COORD_W-1:COORD_W]};

    // Exchange and destination index rebuild
    ttr_rebuild #(.VALUE_WIDTH(VALUE_WIDTH)) u_rebuild (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (eff),
        .in_valid  (v2),
        .in_ready  (r2),
        .top_quot  (q2),
        .coord_in  (coord_low),
        .value_in  (side2[SIDE2_W-1:2*COORD_W]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ src/ttr_checker.sv @@
`timescale 1ns / 1ps

module ttr_checker
    import ttr_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // Stalled result holds its place and contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // With the output register empty nothing can back-pressure the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    // A flagged result carries destination zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_error |-> out_data.dest_index == '0)
        else $error("range error with nonzero destination");

    // Value bits above VALUE_WIDTH are cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_value >> VALUE_WIDTH) == '0)
        else $error("value bits above the configured width are set");

endmodule

bind tensor_transpose_remap ttr_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (.*);
